// ===== rtl/core/tmsn_pkg.sv =====
`default_nettype none

package tmsn_pkg;

   // converter and field widths
   localparam int ADC_BITS   = 12;
   localparam int SAMPLE_W   = 12;
   localparam int NCH        = 4;
   localparam int ROWS       = 3;
   localparam int ROW_W      = 2;
   localparam int CH_W       = 2;
   localparam int MAX_W      = 12;
   localparam int GAIN_W     = 10;
   localparam int RAW_W      = 13;
   localparam int NORM_W     = 15;
   localparam int ERR_W      = 19;
   localparam int S_W        = ADC_BITS + 1;
   localparam int CLIP_W     = MAX_W + 1;
   localparam int SCALE_W    = 14;
   localparam int NPROD_W    = CLIP_W + SCALE_W;
   localparam int EPROD_W    = GAIN_W + NORM_W;
   localparam int Q8_SHIFT   = 8;
   localparam int PROD_W     = EPROD_W + Q8_SHIFT;
   localparam int QUO_W      = 18;
   localparam int CNT_W      = 5;
   localparam int SUMN_W     = NORM_W + 1;
   localparam int NORM_ITER  = NORM_W;
   localparam int ERR_ITER   = QUO_W;

   localparam logic [SCALE_W-1:0] NORM_SCALE = SCALE_W'(12800);
   localparam logic [SUMN_W-1:0]  WEAK_LIMIT = SUMN_W'(1280);
   localparam logic [MAX_W-1:0]   MAX_RESET  = MAX_W'(100);
   localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(100);

   // stream and register port widths
   localparam int REQ_DATA_W = NCH * SAMPLE_W;
   localparam int RSP_BITS   = NCH * (RAW_W + NORM_W) + ERR_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = MAX_W;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CH0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CH1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CH2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CH3    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_GAIN = 3'd4;

   // microprogram
   localparam int PC_W = 4;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_TRIM,
      OP_CLAMP,
      OP_MUL_N,
      OP_LOAD_N,
      OP_DIV_STEP,
      OP_STORE_N,
      OP_SUM,
      OP_MUL_E,
      OP_LOAD_E,
      OP_STORE_E,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      JC_NEXT,
      JC_LOOP_DIV,
      JC_LOOP_CH,
      JC_FINISH
   } jc_type;

   typedef struct packed {
      op_type            op;
      jc_type            jc;
      logic [PC_W-1:0]   target;
   } ctrl_type;

   localparam logic [PC_W-1:0] STEP_TRIM    = 4'd0;
   localparam logic [PC_W-1:0] STEP_CLAMP   = 4'd1;
   localparam logic [PC_W-1:0] STEP_MUL_N   = 4'd2;
   localparam logic [PC_W-1:0] STEP_LOAD_N  = 4'd3;
   localparam logic [PC_W-1:0] STEP_DIV_N   = 4'd4;
   localparam logic [PC_W-1:0] STEP_STORE_N = 4'd5;
   localparam logic [PC_W-1:0] STEP_SUM     = 4'd6;
   localparam logic [PC_W-1:0] STEP_MUL_E   = 4'd7;
   localparam logic [PC_W-1:0] STEP_LOAD_E  = 4'd8;
   localparam logic [PC_W-1:0] STEP_DIV_E   = 4'd9;
   localparam logic [PC_W-1:0] STEP_STORE_E = 4'd10;
   localparam logic [PC_W-1:0] STEP_EMIT    = 4'd11;

   function automatic ctrl_type micro_rom(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = '{op: OP_NOP, jc: JC_FINISH, target: STEP_TRIM};
      case (pc)
         STEP_TRIM:    w = '{op: OP_TRIM,     jc: JC_NEXT,     target: STEP_TRIM};
         STEP_CLAMP:   w = '{op: OP_CLAMP,    jc: JC_NEXT,     target: STEP_TRIM};
         STEP_MUL_N:   w = '{op: OP_MUL_N,    jc: JC_NEXT,     target: STEP_TRIM};
         STEP_LOAD_N:  w = '{op: OP_LOAD_N,   jc: JC_NEXT,     target: STEP_TRIM};
         STEP_DIV_N:   w = '{op: OP_DIV_STEP, jc: JC_LOOP_DIV, target: STEP_DIV_N};
         STEP_STORE_N: w = '{op: OP_STORE_N,  jc: JC_LOOP_CH,  target: STEP_CLAMP};
         STEP_SUM:     w = '{op: OP_SUM,      jc: JC_NEXT,     target: STEP_TRIM};
         STEP_MUL_E:   w = '{op: OP_MUL_E,    jc: JC_NEXT,     target: STEP_TRIM};
         STEP_LOAD_E:  w = '{op: OP_LOAD_E,   jc: JC_NEXT,     target: STEP_TRIM};
         STEP_DIV_E:   w = '{op: OP_DIV_STEP, jc: JC_LOOP_DIV, target: STEP_DIV_E};
         STEP_STORE_E: w = '{op: OP_STORE_E,  jc: JC_NEXT,     target: STEP_TRIM};
         STEP_EMIT:    w = '{op: OP_EMIT,     jc: JC_FINISH,   target: STEP_TRIM};
         default:      w = '{op: OP_NOP,      jc: JC_FINISH,   target: STEP_TRIM};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/trimmed_mean_sensor_normalizer.sv =====
// four-channel trimmed-mean normaliser with a difference-over-sum steering error
//
// req channel: one transfer carries one round of four samples. rounds one to
// three are written into the sample store in the transfer cycle and req_tready
// stays high. the fourth round starts a microcoded sequencer and req_tready
// drops until the result has been loaded into the output register.
// csr channel: register writes (max_ch0..3 at index 0..3, ratio_gain at 4),
// always ready outside reset, unknown indexes are ignored.
// rsp channel: one transfer per four-round frame with sums, levels and error.
// steps from the fourth-round transfer to rsp_tvalid: 1 trim step,
// 4 x (clamp, multiply, load, 15 divide steps, store), then sum,
// multiply, load, 18 divide steps, store and the output load.
// the serial restoring divider gives one quotient bit per cycle.
// a stalled receiver holds the result; the next frame runs to the output
// load and waits there until the register frees, earlier rounds still flow.
// reset (synchronous, active high) clears the round count and the sequencer,
// drops rsp_tvalid and puts 100 into all five registers; stored samples are
// left as they are and only read after being rewritten.

`default_nettype none

module trimmed_mean_sensor_normalizer
   import tmsn_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // sample_ch0, sample_ch1, sample_ch2, sample_ch3
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // raw_sum_ch0..3, norm_ch0..3, steer_error, zero fill
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // control state
   logic                     busy_ff, busy_in;
   logic [PC_W-1:0]          pc_ff, pc_in;
   logic [CH_W-1:0]          ch_ff, ch_in;
   logic [ROW_W-1:0]         round_ff, round_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MAX_W-1:0]         max_ff [NCH];
   logic [MAX_W-1:0]         max_in [NCH];
   logic [GAIN_W-1:0]        gain_ff, gain_in;

   // datapath
   logic [ADC_BITS-1:0]      store_ff [ROWS][NCH];
   logic [ADC_BITS-1:0]      store_in [NCH];
   logic                     store_we;
   logic [ADC_BITS-1:0]      cur_ff [NCH];
   logic [ADC_BITS-1:0]      cur_in [NCH];
   logic [S_W-1:0]           s_ff [NCH];
   logic [S_W-1:0]           s_in [NCH];
   logic [CLIP_W-1:0]        clip_ff, clip_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [PROD_W-1:0]        rem_ff, rem_in;
   logic [PROD_W-1:0]        dsr_ff, dsr_in;
   logic [QUO_W-1:0]         q_ff, q_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [NORM_W-1:0]        norm_ff [NCH];
   logic [NORM_W-1:0]        norm_in [NCH];
   logic [SUMN_W-1:0]        sum_ff, sum_in;
   logic [NORM_W-1:0]        absd_ff, absd_in;
   logic                     neg_ff, neg_in;
   logic                     weak_ff, weak_in;
   logic [ERR_W-1:0]         err_ff, err_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   ctrl_type                 ctrl;
   logic                     req_xfer;
   logic                     csr_xfer;
   logic                     out_free;
   logic [MAX_W-1:0]         m_sel;
   logic [S_W-1:0]           s_sel;
   logic [CLIP_W-1:0]        dbl;
   logic [NPROD_W-1:0]       nprod;
   logic [EPROD_W-1:0]       eprod;
   logic                     ge;

   // middle pair of four: total less the smallest and the largest
   function automatic logic [S_W-1:0] middle_pair(
      input logic [ADC_BITS-1:0] a,
      input logic [ADC_BITS-1:0] b,
      input logic [ADC_BITS-1:0] c,
      input logic [ADC_BITS-1:0] d
   );
      logic [ADC_BITS-1:0] lo_ab, lo_cd, hi_ab, hi_cd, lo, hi;
      logic [ADC_BITS+1:0] tot;
      lo_ab = (a < b) ? a : b;
      hi_ab = (a < b) ? b : a;
      lo_cd = (c < d) ? c : d;
      hi_cd = (c < d) ? d : c;
      lo    = (lo_ab < lo_cd) ? lo_ab : lo_cd;
      hi    = (hi_ab > hi_cd) ? hi_ab : hi_cd;
      tot   = (ADC_BITS+2)'(a) + (ADC_BITS+2)'(b) + (ADC_BITS+2)'(c)
            + (ADC_BITS+2)'(d);
      tot   = tot - (ADC_BITS+2)'(lo) - (ADC_BITS+2)'(hi);
      return S_W'(tot);
   endfunction

   assign req_tready = !busy_ff && !reset;
   assign csr_ready  = !reset;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_xfer   = csr_valid && csr_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   // output register can take a new result this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // control word of the current step
   assign ctrl  = micro_rom(pc_ff);
   assign m_sel = max_ff[ch_ff];
   assign s_sel = s_ff[ch_ff];
   assign dbl   = {m_sel, 1'b0};
   assign nprod = clip_ff * NORM_SCALE;
   assign eprod = gain_ff * absd_ff;
   assign ge    = rem_ff >= dsr_ff;

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      ch_in        = ch_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff;
      gain_in      = gain_ff;
      store_we     = 1'b0;
      clip_in      = clip_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      absd_in      = absd_ff;
      neg_in       = neg_ff;
      weak_in      = weak_ff;
      err_in       = err_ff;
      rsp_data_in  = rsp_data_ff;
      for (int c = 0; c < NCH; c++) begin
         max_in[c]   = max_ff[c];
         store_in[c] = ADC_BITS'(req_tdata[c*SAMPLE_W +: SAMPLE_W]);
         cur_in[c]   = cur_ff[c];
         s_in[c]     = s_ff[c];
         norm_in[c]  = norm_ff[c];
      end

      // receiver took the result
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_xfer) begin
         case (csr_index)
            CSR_MAX_CH0:    max_in[0] = csr_data[MAX_W-1:0];
            CSR_MAX_CH1:    max_in[1] = csr_data[MAX_W-1:0];
            CSR_MAX_CH2:    max_in[2] = csr_data[MAX_W-1:0];
            CSR_MAX_CH3:    max_in[3] = csr_data[MAX_W-1:0];
            CSR_RATIO_GAIN: gain_in   = csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end

      // round intake: first three rounds go to the store, the fourth starts the program
      if (req_xfer) begin
         if (round_ff == ROW_W'(ROWS)) begin
            round_in = '0;
            busy_in  = 1'b1;
            pc_in    = STEP_TRIM;
            ch_in    = '0;
            for (int c = 0; c < NCH; c++) begin
               cur_in[c] = store_in[c];
            end
         end else begin
            store_we = 1'b1;
            round_in = round_ff + 1'b1;
         end
      end

      if (busy_ff) begin
         // datapath action of the step
         case (ctrl.op)
            OP_TRIM: begin
               for (int c = 0; c < NCH; c++) begin
                  s_in[c] = middle_pair(store_ff[0][c], store_ff[1][c],
                                        store_ff[2][c], cur_ff[c]);
               end
            end
            OP_CLAMP: begin
               clip_in = (s_sel > dbl) ? dbl : CLIP_W'(s_sel);
            end
            OP_MUL_N: begin
               prod_in = PROD_W'(nprod);
            end
            OP_LOAD_N: begin
               rem_in = prod_ff;
               dsr_in = PROD_W'(m_sel) << (NORM_ITER - 1);
               q_in   = '0;
               cnt_in = CNT_W'(NORM_ITER - 1);
            end
            OP_DIV_STEP: begin
               if (ge) begin
                  rem_in = rem_ff - dsr_ff;
               end
               q_in   = {q_ff[QUO_W-2:0], ge};
               dsr_in = dsr_ff >> 1;
               cnt_in = cnt_ff - 1'b1;
            end
            OP_STORE_N: begin
               // zero full scale gives a zero level
               norm_in[ch_ff] = (m_sel == '0) ? '0 : q_ff[NORM_W-1:0];
               ch_in          = ch_ff + 1'b1;
            end
            OP_SUM: begin
               sum_in  = SUMN_W'(norm_ff[0]) + SUMN_W'(norm_ff[NCH-1]);
               neg_in  = norm_ff[NCH-1] < norm_ff[0];
               absd_in = (norm_ff[NCH-1] < norm_ff[0]) ? norm_ff[0] - norm_ff[NCH-1]
                                                       : norm_ff[NCH-1] - norm_ff[0];
               weak_in = sum_in <= WEAK_LIMIT;
            end
            OP_MUL_E: begin
               prod_in = {eprod, {Q8_SHIFT{1'b0}}};
            end
            OP_LOAD_E: begin
               rem_in = prod_ff;
               dsr_in = PROD_W'(sum_ff) << (ERR_ITER - 1);
               q_in   = '0;
               cnt_in = CNT_W'(ERR_ITER - 1);
            end
            OP_STORE_E: begin
               // weak signal forces zero; quotient magnitude gets the sign of the difference
               if (weak_ff) begin
                  err_in = '0;
               end else if (neg_ff) begin
                  err_in = ERR_W'(0) - ERR_W'(q_ff);
               end else begin
                  err_in = ERR_W'(q_ff);
               end
            end
            OP_EMIT: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  for (int c = 0; c < NCH; c++) begin
                     rsp_data_in[c*RAW_W +: RAW_W] = RAW_W'(s_ff[c]);
                     rsp_data_in[NCH*RAW_W + c*NORM_W +: NORM_W] = norm_ff[c];
                  end
                  rsp_data_in[NCH*(RAW_W+NORM_W) +: ERR_W] = err_ff;
               end
            end
            default: ;
         endcase

         // step sequencing
         case (ctrl.jc)
            JC_NEXT: begin
               pc_in = pc_ff + 1'b1;
            end
            JC_LOOP_DIV: begin
               pc_in = (cnt_ff != '0) ? ctrl.target : pc_ff + 1'b1;
            end
            JC_LOOP_CH: begin
               pc_in = (ch_ff != CH_W'(NCH - 1)) ? ctrl.target : pc_ff + 1'b1;
            end
            JC_FINISH: begin
               if (out_free) begin
                  busy_in = 1'b0;
                  pc_in   = STEP_TRIM;
               end
            end
            default: begin
               busy_in = 1'b0;
               pc_in   = STEP_TRIM;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= STEP_TRIM;
         ch_ff        <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= GAIN_RESET;
         for (int c = 0; c < NCH; c++) begin
            max_ff[c] <= MAX_RESET;
         end
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         ch_ff        <= ch_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         for (int c = 0; c < NCH; c++) begin
            max_ff[c] <= max_in[c];
         end
      end
   end

   // sample store, one row per round
   always_ff @(posedge clock) begin
      if (store_we) begin
         for (int c = 0; c < NCH; c++) begin
            store_ff[round_ff][c] <= store_in[c];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      clip_ff     <= clip_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      dsr_ff      <= dsr_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      sum_ff      <= sum_in;
      absd_ff     <= absd_in;
      neg_ff      <= neg_in;
      weak_ff     <= weak_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      for (int c = 0; c < NCH; c++) begin
         cur_ff[c]  <= cur_in[c];
         s_ff[c]    <= s_in[c];
         norm_ff[c] <= norm_in[c];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tmsn_checker.sv =====
`default_nettype none

module tmsn_checker
   import tmsn_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped under stall");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed under stall");

   // intake closes only after a round was transferred
   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid))
      else $error("req_tready fell without a transfer");

   // a new result only comes out of a running frame computation
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while intake was open");

endmodule

bind trimmed_mean_sensor_normalizer tmsn_checker u_tmsn_checker (.*);

`default_nettype wire
